@@ rtl/keyframe_vector_interpolator_defines.svh @@
// Assertion macros shared by the keyframe vector interpolator RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define KVI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define KVI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kvi_pkg.sv @@
// Shared types and constants for the keyframe vector interpolator.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kvi_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [INDEX_W-1:0]       key_index;
        logic [DATA_W-1:0]        key_time;
        logic signed [DATA_W-1:0] key_x;
        logic signed [DATA_W-1:0] key_y;
        logic signed [DATA_W-1:0] key_z;
        logic [DATA_W-1:0]        query_time;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
    } out_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]        key_time;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } key_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/kvi_cell.sv @@
// One keyframe cell of the rotating key table.
// Depends on kvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvi_cell
(
    input  wire logic              clk,
    input  wire kvi_pkg::cell_ctl_t ctl,
    input  wire kvi_pkg::key_t     load_data,
    input  wire kvi_pkg::key_t     shift_data,
    output kvi_pkg::key_t          data
);

    kvi_pkg::key_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= load_data;
        end
        else if (ctl.shift)
        begin
            data_reg <= shift_data;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ rtl/kvi_div.sv @@
// Restoring divider forming the unsigned segment fraction one bit per cycle.
// Depends on kvi_pkg; expects the numerator not to exceed the denominator.
`timescale 1ns / 1ps
`default_nettype none

module kvi_div #(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [kvi_pkg::DATA_W-1:0]  num,
    input  wire logic [kvi_pkg::DATA_W-1:0]  den,
    output logic                             done,
    output logic [FRAC_BITS:0]               quo
);

    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam int DW = kvi_pkg::DATA_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;

    logic          first_ge;
    logic [DW:0]   rem_shift;
    logic          step_ge;

    assign first_ge  = (num >= den);
    assign rem_shift = {rem_reg, 1'b0};
    assign step_ge   = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= first_ge ? (num - den) : num;
            quo_reg <= QW'(first_ge);
        end
        else if (busy_reg)
        begin
            rem_reg <= step_ge ? DW'(rem_shift - {1'b0, den_reg}) : rem_shift[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], step_ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ rtl/kvi_lerp.sv @@
// Shared multiplier that blends the three components one after another.
// Depends on kvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvi_lerp #(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire kvi_pkg::out_word_t  a,
    input  wire kvi_pkg::out_word_t  b,
    input  wire logic [FRAC_BITS:0]  frac,
    output logic                     done,
    output kvi_pkg::out_word_t       result
);

    localparam int DW = kvi_pkg::DATA_W;
    localparam int PW = DW + 1 + FRAC_BITS + 2;

    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         step_reg;
    kvi_pkg::out_word_t a_reg;
    kvi_pkg::out_word_t b_reg;
    logic [FRAC_BITS:0] frac_reg;
    logic signed [PW-1:0] prod_reg;
    kvi_pkg::out_word_t res_reg;

    logic signed [DW-1:0] a_mul;
    logic signed [DW-1:0] b_mul;
    logic signed [DW-1:0] a_acc;
    logic signed [DW:0]   diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_shift;
    logic signed [DW-1:0] sum;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                a_mul = a_reg.out_x;
                b_mul = b_reg.out_x;
            end
            2'd1:
            begin
                a_mul = a_reg.out_y;
                b_mul = b_reg.out_y;
            end
            default:
            begin
                a_mul = a_reg.out_z;
                b_mul = b_reg.out_z;
            end
        endcase
        case (step_reg)
            2'd1:    a_acc = a_reg.out_x;
            2'd2:    a_acc = a_reg.out_y;
            default: a_acc = a_reg.out_z;
        endcase
    end

    assign diff       = (DW+1)'(b_mul) - (DW+1)'(a_mul);
    assign prod_next  = PW'(diff) * $signed(PW'({1'b0, frac_reg}));
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign sum        = a_acc + prod_shift[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            b_reg    <= b;
            frac_reg <= frac;
        end
        else if (busy_reg)
        begin
            if (step_reg != 2'd3)
            begin
                prod_reg <= prod_next;
            end
            case (step_reg)
                2'd1:    res_reg.out_x <= sum;
                2'd2:    res_reg.out_y <= sum;
                2'd3:    res_reg.out_z <= sum;
                default: res_reg <= res_reg;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ rtl/keyframe_vector_interpolator.sv @@
// Top level of the keyframe vector interpolator: key table, search and control.
// Depends on kvi_pkg, kvi_cell, kvi_div, kvi_lerp and the assertion header.
//
// Usage. Input words arrive on in_valid/in_stall/in_data. A load word (op clear)
// writes one keyframe into its slot. A query word (op set) produces one output
// word on out_valid/out_stall/out_data. A query rotates the key table once
// through its cells; a result that needs blending then passes through the
// divider and the multiplier, and every result then moves into the output
// register. The next word is accepted only after that move. One word is
// handled at a time; in_stall is high while a query is in progress.
// The key count is written on cfg_valid/cfg_ready/cfg_data while the block is idle.
// Reset sets the key count to one and empties the output register; table
// contents are undefined until loaded. While the receiver stalls, the output
// register holds its word and a further query waits at its end for it to drain.
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_vector_interpolator_defines.svh"

module keyframe_vector_interpolator #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire kvi_pkg::in_word_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output kvi_pkg::out_word_t                out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [kvi_pkg::COUNT_W-1:0]  cfg_data
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int DW = kvi_pkg::DATA_W;
    localparam logic [IW-1:0] LAST = IW'(MAX_KEYS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_LERP   = 3'd3;
    localparam logic [2:0] ST_RES    = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [kvi_pkg::COUNT_W-1:0] count_reg;
    logic [IW-1:0]               cnt_reg;
    logic                        decided_reg;
    logic                        lerp_reg;
    logic                        out_valid_reg;
    kvi_pkg::out_word_t          out_data_reg;
    logic [DW-1:0]               qtime_reg;
    kvi_pkg::out_word_t          res_reg;
    kvi_pkg::out_word_t          a_reg;
    kvi_pkg::out_word_t          b_reg;
    logic [DW-1:0]               num_reg;
    logic [DW-1:0]               den_reg;

    logic                        in_accept;
    logic                        load_hit;
    logic                        query_hit;
    logic                        in_search;
    logic                        search_last;
    logic                        out_take;
    logic                        out_load;
    logic [NW-1:0]               n_eff;
    logic [NW-1:0]               cnt_plus;
    kvi_pkg::key_t               load_key;
    kvi_pkg::key_t               head0;
    kvi_pkg::key_t               head1;
    kvi_pkg::out_word_t          head0_vec;
    kvi_pkg::out_word_t          head1_vec;
    logic                        first_now;
    logic                        seg_hit;
    logic                        last_now;
    logic                        decide_now;
    logic                        div_start;
    logic                        div_done;
    logic [FRAC_BITS:0]          div_quo;
    logic                        lerp_done;
    kvi_pkg::out_word_t          lerp_res;

    kvi_pkg::key_t               cell_data [MAX_KEYS];
    kvi_pkg::cell_ctl_t          cell_ctl  [MAX_KEYS];

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign load_hit    = in_accept && (in_data.op == kvi_pkg::OP_LOAD)
                         && (32'(in_data.key_index) < MAX_KEYS);
    assign query_hit   = in_accept && (in_data.op == kvi_pkg::OP_QUERY);
    assign in_search   = (state_reg == ST_SEARCH);
    assign search_last = in_search && (cnt_reg == LAST);
    assign out_take    = out_valid_reg && !out_stall;
    assign out_load    = (state_reg == ST_RES) && (!out_valid_reg || out_take);

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(count_reg) > MAX_KEYS)
        begin
            n_eff = NW'(MAX_KEYS);
        end
        else
        begin
            n_eff = NW'(count_reg);
        end
    end

    assign load_key.key_time = in_data.key_time;
    assign load_key.x        = in_data.key_x;
    assign load_key.y        = in_data.key_y;
    assign load_key.z        = in_data.key_z;

    for (genvar k = 0; k < MAX_KEYS; k++)
    begin : g_cell
        assign cell_ctl[k].load  = load_hit && (32'(in_data.key_index) == k);
        assign cell_ctl[k].shift = in_search;

        kvi_cell u_cell
        (
            .clk        (clk),
            .ctl        (cell_ctl[k]),
            .load_data  (load_key),
            .shift_data (cell_data[(k + 1) % MAX_KEYS]),
            .data       (cell_data[k])
        );
    end

    assign head0 = cell_data[0];
    assign head1 = cell_data[1];
    assign head0_vec.out_x = head0.x;
    assign head0_vec.out_y = head0.y;
    assign head0_vec.out_z = head0.z;
    assign head1_vec.out_x = head1.x;
    assign head1_vec.out_y = head1.y;
    assign head1_vec.out_z = head1.z;

    assign cnt_plus   = NW'(cnt_reg) + NW'(1);
    assign first_now  = (cnt_reg == '0) && ((n_eff == NW'(1)) || (qtime_reg <= head0.key_time));
    assign seg_hit    = (cnt_plus < n_eff) && (head0.key_time <= qtime_reg)
                        && (qtime_reg <= head1.key_time);
    assign last_now   = (cnt_plus == n_eff);
    assign decide_now = in_search && !decided_reg && (first_now || seg_hit || last_now);

    assign div_start  = search_last && lerp_reg;

    kvi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    kvi_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_done),
        .a      (a_reg),
        .b      (b_reg),
        .frac   (div_quo),
        .done   (lerp_done),
        .result (lerp_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_hit)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = lerp_reg ? ST_DIV : ST_RES;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LERP;
                end
            end
            ST_LERP:
            begin
                if (lerp_done)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= kvi_pkg::COUNT_W'(1);
            cnt_reg       <= '0;
            decided_reg   <= 1'b0;
            lerp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (query_hit)
            begin
                cnt_reg     <= '0;
                decided_reg <= 1'b0;
                lerp_reg    <= 1'b0;
            end
            else if (in_search)
            begin
                cnt_reg <= cnt_reg + IW'(1);
                if (decide_now)
                begin
                    decided_reg <= 1'b1;
                    lerp_reg    <= !first_now && seg_hit && (head0.key_time != head1.key_time);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_hit)
        begin
            qtime_reg <= in_data.query_time;
        end
        if (decide_now)
        begin
            res_reg <= head0_vec;
            a_reg   <= head0_vec;
            b_reg   <= head1_vec;
            num_reg <= qtime_reg - head0.key_time;
            den_reg <= head1.key_time - head0.key_time;
        end
        else if (lerp_done)
        begin
            res_reg <= lerp_res;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `KVI_ASSERT_IMP(a_decided, search_last, decided_reg || decide_now, "search ended undecided")
    `KVI_ASSERT_IMP(a_div_state, div_done, state_reg == ST_DIV, "divider finished out of turn")
    `KVI_ASSERT_IMP(a_lerp_state, lerp_done, state_reg == ST_LERP, "blend finished out of turn")
    `KVI_ASSERT_NXT(a_res_hold, (state_reg == ST_RES) && out_valid_reg && out_stall,
                    state_reg == ST_RES, "result left while output register was full")

endmodule

`default_nettype wire
